### rtl/core/spsfs_pkg.sv
// Shared types and constants for the SPS frame-size parser.
`default_nettype none
package spsfs_pkg;
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TRUNCATED = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_PROFILE, ST_CONSTRAINT, ST_LEVEL, ST_SPS_ID, ST_CHROMA, ST_RESIDUAL,
		ST_DEPTH_LUMA, ST_DEPTH_CHROMA, ST_BYPASS, ST_MATRIX_FLAG, ST_LIST_FLAG,
		ST_DELTA, ST_LOG2_FRAME, ST_POC_TYPE, ST_POC_LSB, ST_ZERO_FLAG, ST_NONREF,
		ST_TOPBOT, ST_CYCLE_LEN, ST_CYCLE_OFF, ST_REF_FRAMES, ST_GAPS, ST_WIDTH,
		ST_HEIGHT, ST_FRAMES_ONLY, ST_ADAPTIVE, ST_DIRECT, ST_CROP_FLAG, ST_CROP,
		ST_VUI
	} field_t;

	// Handshake from the bit decoder to the field sequencer.
	typedef struct packed {
		logic        done;
		logic [31:0] value;
		logic        malformed;
	} code_t;

	localparam logic [7:0] PROF_100 = 8'd100;
	localparam logic [7:0] PROF_110 = 8'd110;
	localparam logic [7:0] PROF_122 = 8'd122;
	localparam logic [7:0] PROF_244 = 8'd244;
	localparam logic [7:0] PROF_44  = 8'd44;
	localparam logic [7:0] PROF_83  = 8'd83;
	localparam logic [7:0] PROF_86  = 8'd86;
	localparam logic [7:0] PROF_118 = 8'd118;

	// Fixed bit count of a field; zero marks an Exp-Golomb code.
	function automatic logic [3:0] fixed_bits(input field_t f);
		case (f)
			ST_PROFILE, ST_CONSTRAINT, ST_LEVEL: fixed_bits = 4'd8;
			ST_RESIDUAL, ST_BYPASS, ST_MATRIX_FLAG, ST_LIST_FLAG, ST_ZERO_FLAG,
			ST_GAPS, ST_FRAMES_ONLY, ST_ADAPTIVE, ST_DIRECT, ST_CROP_FLAG,
			ST_VUI: fixed_bits = 4'd1;
			default: fixed_bits = 4'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

### rtl/core/sps_frame_size_parser_core.sv
// Top level of the SPS frame-size parser: byte shifter, field sequencer and result register.
// An accepted request byte is shifted out MSB first, one bit per cycle, into a bit-serial
// Exp-Golomb decoder; a byte marked last then goes through P_END, a byte arriving after the
// result leaves P_SHIFT after one bit. A malformed result is registered with its bit, the size
// result in P_MATH after the VUI flag bit and a truncated result in P_END after the last bit.
// A waiting result holds off the next request until taken; arst_n clears all state at once.
`default_nettype none
module sps_frame_size_parser_core #(
	parameter int MAX_PREFIX_ZEROS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // payload_byte[7:0]
	input  wire logic        s_tlast,  // end_of_unit
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // frame_width[15:0], frame_height[31:16], parse_status[33:32]
);
	typedef enum logic [1:0] {P_IDLE, P_SHIFT, P_MATH, P_END} phase_t;

	phase_t      phase_q;
	logic [7:0]  shift_q;
	logic [3:0]  bitcnt_q;
	logic        last_q;
	logic        finished_q;
	spsfs_pkg::field_t stage_q;
	logic [7:0]  profile_q;
	logic [3:0]  list_q;
	logic [6:0]  entry_q;
	logic [7:0]  last_scale_q;
	logic [7:0]  next_scale_q;
	logic [31:0] cycle_q;
	logic [31:0] wmb_q;
	logic [31:0] hun_q;
	logic        frames_only_q;
	logic [31:0] crop_q [4];
	logic [31:0] w_q, h_q;
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        restart;
	logic        bit_valid;
	spsfs_pkg::code_t code;
	logic        prof_high;
	logic [7:0]  delta_s;
	logic [7:0]  scale_sum;

	// The decoder restarts whenever a new field is entered.
	logic        enter_field;

	spsfs_bit_decoder #(.MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)) u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.bit_valid  (bit_valid),
		.bit_in     (shift_q[7]),
		.restart    (restart),
		.fixed_width(spsfs_pkg::fixed_bits(stage_q)),
		.code       (code)
	);

	assign bit_valid = (phase_q == P_SHIFT) && !finished_q;
	assign restart   = enter_field;
	assign s_tready  = (phase_q == P_IDLE) && !(out_valid_q && !m_tready);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign prof_high = profile_q == spsfs_pkg::PROF_100 || profile_q == spsfs_pkg::PROF_110 ||
		profile_q == spsfs_pkg::PROF_122 || profile_q == spsfs_pkg::PROF_244 ||
		profile_q == spsfs_pkg::PROF_44 || profile_q == spsfs_pkg::PROF_83 ||
		profile_q == spsfs_pkg::PROF_86 || profile_q == spsfs_pkg::PROF_118;

	// Signed mapping of the delta code, taken mod 256.
	assign delta_s   = code.value[0] ? (code.value[8:1] + 8'd1) : (8'd0 - code.value[8:1]);
	assign scale_sum = last_scale_q + delta_s;

	assign enter_field = code.done || (phase_q == P_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= P_IDLE;
			shift_q       <= '0;
			bitcnt_q      <= '0;
			last_q        <= 1'b0;
			finished_q    <= 1'b0;
			stage_q       <= spsfs_pkg::ST_PROFILE;
			profile_q     <= '0;
			list_q        <= '0;
			entry_q       <= '0;
			last_scale_q  <= 8'd8;
			next_scale_q  <= 8'd8;
			cycle_q       <= '0;
			wmb_q         <= '0;
			hun_q         <= '0;
			frames_only_q <= 1'b0;
			for (int i = 0; i < 4; i++) crop_q[i] <= '0;
			w_q           <= '0;
			h_q           <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (s_tvalid && s_tready) begin
						shift_q  <= s_tdata;
						last_q   <= s_tlast;
						bitcnt_q <= 4'd0;
						phase_q  <= P_SHIFT;
					end
				end
				P_SHIFT: begin
					shift_q  <= {shift_q[6:0], 1'b0};
					bitcnt_q <= bitcnt_q + 4'd1;
					// The byte ends early once a result is due or the parser has finished.
					if (bit_valid && code.malformed)
						phase_q <= last_q ? P_END : P_IDLE;
					else if (code.done && stage_q == spsfs_pkg::ST_VUI)
						phase_q <= P_MATH;
					else if (bitcnt_q == 4'd7 || finished_q)
						phase_q <= last_q ? P_END : P_IDLE;
					if (bit_valid && code.malformed) begin
						finished_q  <= 1'b1;
						out_valid_q <= 1'b1;
						out_data_q  <= {6'd0, spsfs_pkg::STATUS_MALFORMED, 32'd0};
					end else if (code.done) begin
						case (stage_q)
							spsfs_pkg::ST_PROFILE: begin
								profile_q <= code.value[7:0];
								stage_q   <= spsfs_pkg::ST_CONSTRAINT;
							end
							spsfs_pkg::ST_CONSTRAINT: stage_q <= spsfs_pkg::ST_LEVEL;
							spsfs_pkg::ST_LEVEL:      stage_q <= spsfs_pkg::ST_SPS_ID;
							spsfs_pkg::ST_SPS_ID:
								stage_q <= prof_high ? spsfs_pkg::ST_CHROMA
									: spsfs_pkg::ST_LOG2_FRAME;
							spsfs_pkg::ST_CHROMA:
								stage_q <= (code.value == 32'd3) ? spsfs_pkg::ST_RESIDUAL
									: spsfs_pkg::ST_DEPTH_LUMA;
							spsfs_pkg::ST_RESIDUAL:     stage_q <= spsfs_pkg::ST_DEPTH_LUMA;
							spsfs_pkg::ST_DEPTH_LUMA:   stage_q <= spsfs_pkg::ST_DEPTH_CHROMA;
							spsfs_pkg::ST_DEPTH_CHROMA: stage_q <= spsfs_pkg::ST_BYPASS;
							spsfs_pkg::ST_BYPASS:       stage_q <= spsfs_pkg::ST_MATRIX_FLAG;
							spsfs_pkg::ST_MATRIX_FLAG: begin
								list_q  <= '0;
								stage_q <= code.value[0] ? spsfs_pkg::ST_LIST_FLAG
									: spsfs_pkg::ST_LOG2_FRAME;
							end
							spsfs_pkg::ST_LIST_FLAG: begin
								if (code.value[0]) begin
									// A present list starts with next scale eight: a delta follows.
									entry_q      <= '0;
									last_scale_q <= 8'd8;
									next_scale_q <= 8'd8;
									stage_q      <= spsfs_pkg::ST_DELTA;
								end else begin
									list_q  <= list_q + 4'd1;
									stage_q <= (list_q < 4'd7) ? spsfs_pkg::ST_LIST_FLAG
										: spsfs_pkg::ST_LOG2_FRAME;
								end
							end
							spsfs_pkg::ST_DELTA: begin
								next_scale_q <= scale_sum;
								if (scale_sum != 8'd0)
									last_scale_q <= scale_sum;
								// A zero next scale skips the rest of the list.
								if (scale_sum != 8'd0 &&
									entry_q + 7'd1 < ((list_q < 4'd6) ? 7'd16 : 7'd64)) begin
									entry_q <= entry_q + 7'd1;
									stage_q <= spsfs_pkg::ST_DELTA;
								end else begin
									list_q  <= list_q + 4'd1;
									stage_q <= (list_q < 4'd7) ? spsfs_pkg::ST_LIST_FLAG
										: spsfs_pkg::ST_LOG2_FRAME;
								end
							end
							spsfs_pkg::ST_LOG2_FRAME: stage_q <= spsfs_pkg::ST_POC_TYPE;
							spsfs_pkg::ST_POC_TYPE:
								stage_q <= (code.value == 32'd0) ? spsfs_pkg::ST_POC_LSB
									: (code.value == 32'd1) ? spsfs_pkg::ST_ZERO_FLAG
									: spsfs_pkg::ST_REF_FRAMES;
							spsfs_pkg::ST_POC_LSB:   stage_q <= spsfs_pkg::ST_REF_FRAMES;
							spsfs_pkg::ST_ZERO_FLAG: stage_q <= spsfs_pkg::ST_NONREF;
							spsfs_pkg::ST_NONREF:    stage_q <= spsfs_pkg::ST_TOPBOT;
							spsfs_pkg::ST_TOPBOT:    stage_q <= spsfs_pkg::ST_CYCLE_LEN;
							spsfs_pkg::ST_CYCLE_LEN: begin
								cycle_q <= code.value;
								stage_q <= (code.value != 32'd0) ? spsfs_pkg::ST_CYCLE_OFF
									: spsfs_pkg::ST_REF_FRAMES;
							end
							spsfs_pkg::ST_CYCLE_OFF: begin
								cycle_q <= cycle_q - 32'd1;
								stage_q <= (cycle_q != 32'd1) ? spsfs_pkg::ST_CYCLE_OFF
									: spsfs_pkg::ST_REF_FRAMES;
							end
							spsfs_pkg::ST_REF_FRAMES: stage_q <= spsfs_pkg::ST_GAPS;
							spsfs_pkg::ST_GAPS:       stage_q <= spsfs_pkg::ST_WIDTH;
							spsfs_pkg::ST_WIDTH: begin
								wmb_q   <= code.value;
								stage_q <= spsfs_pkg::ST_HEIGHT;
							end
							spsfs_pkg::ST_HEIGHT: begin
								hun_q   <= code.value;
								stage_q <= spsfs_pkg::ST_FRAMES_ONLY;
							end
							spsfs_pkg::ST_FRAMES_ONLY: begin
								frames_only_q <= code.value[0];
								stage_q <= code.value[0] ? spsfs_pkg::ST_DIRECT
									: spsfs_pkg::ST_ADAPTIVE;
							end
							spsfs_pkg::ST_ADAPTIVE: stage_q <= spsfs_pkg::ST_DIRECT;
							spsfs_pkg::ST_DIRECT:   stage_q <= spsfs_pkg::ST_CROP_FLAG;
							spsfs_pkg::ST_CROP_FLAG: begin
								list_q  <= '0;
								stage_q <= code.value[0] ? spsfs_pkg::ST_CROP
									: spsfs_pkg::ST_VUI;
							end
							spsfs_pkg::ST_CROP: begin
								crop_q[list_q[1:0]] <= code.value;
								list_q  <= list_q + 4'd1;
								stage_q <= (list_q < 4'd3) ? spsfs_pkg::ST_CROP
									: spsfs_pkg::ST_VUI;
							end
							spsfs_pkg::ST_VUI: begin
								// Base sizes first; the crop correction follows in P_MATH.
								finished_q <= 1'b1;
								w_q <= (wmb_q + 32'd1) << 4;
								h_q <= frames_only_q ? ((hun_q + 32'd1) << 4)
									: ((hun_q + 32'd1) << 5);
							end
							default: stage_q <= spsfs_pkg::ST_PROFILE;
						endcase
					end
				end
				P_MATH: begin
					out_valid_q <= 1'b1;
					out_data_q  <= {6'd0, spsfs_pkg::STATUS_OK,
						h_q[15:0] - ((crop_q[2][15:0] + crop_q[3][15:0]) << 1),
						w_q[15:0] - ((crop_q[0][15:0] + crop_q[1][15:0]) << 1)};
					phase_q <= last_q ? P_END : P_IDLE;
				end
				P_END: begin
					if (!finished_q) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {6'd0, spsfs_pkg::STATUS_TRUNCATED, 32'd0};
					end
					finished_q    <= 1'b0;
					stage_q       <= spsfs_pkg::ST_PROFILE;
					profile_q     <= '0;
					list_q        <= '0;
					entry_q       <= '0;
					last_scale_q  <= 8'd8;
					next_scale_q  <= 8'd8;
					cycle_q       <= '0;
					wmb_q         <= '0;
					hun_q         <= '0;
					frames_only_q <= 1'b0;
					for (int i = 0; i < 4; i++) crop_q[i] <= '0;
					phase_q       <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> phase_q == P_SHIFT)
		else $error("accepted byte not shifted");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_MATH) |=> out_valid_q)
		else $error("size result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_END) |=> !finished_q && stage_q == spsfs_pkg::ST_PROFILE)
		else $error("end of unit did not restart parser");
	assert property (@(posedge clk) disable iff (!arst_n)
		(next_scale_q == 8'd0) |-> stage_q != spsfs_pkg::ST_DELTA)
		else $error("delta read after zero scale");
endmodule
`default_nettype wire

### rtl/core/spsfs_bit_decoder.sv
// Bit-serial decoder for fixed-width fields and Exp-Golomb codes.
`default_nettype none
module spsfs_bit_decoder #(
	parameter int MAX_PREFIX_ZEROS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             bit_valid,
	input  wire logic             bit_in,
	input  wire logic             restart,
	input  wire logic [3:0]       fixed_width,
	output spsfs_pkg::code_t      code
);
	logic [31:0] acc_q;
	logic [5:0]  zeros_q;
	logic [5:0]  remain_q;
	logic [31:0] acc_next;
	logic [31:0] bias;

	assign acc_next = {acc_q[30:0], bit_in};
	assign bias = (32'd1 << zeros_q[4:0]) - 32'd1;

	always_comb begin
		code = '0;
		if (bit_valid) begin
			if (fixed_width != 4'd0) begin
				code.value = acc_next;
				code.done  = (remain_q == 6'd1) || (remain_q == 6'd0 && fixed_width == 4'd1);
			end else if (remain_q == 6'd0) begin
				if (!bit_in)
					code.malformed = ({26'd0, zeros_q} + 32'd1) >= MAX_PREFIX_ZEROS;
				else if (zeros_q == 6'd0)
					code.done = 1'b1;
			end else begin
				code.value = acc_next + bias;
				code.done  = (remain_q == 6'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			zeros_q  <= '0;
			remain_q <= '0;
		end else if (restart) begin
			acc_q    <= '0;
			zeros_q  <= '0;
			remain_q <= '0;
		end else if (bit_valid) begin
			if (fixed_width != 4'd0) begin
				acc_q <= acc_next;
				if (remain_q == 6'd0)
					remain_q <= {2'd0, fixed_width} - 6'd1;
				else
					remain_q <= remain_q - 6'd1;
			end else if (remain_q == 6'd0) begin
				if (!bit_in)
					zeros_q <= zeros_q + 6'd1;
				else begin
					remain_q <= zeros_q;
					acc_q    <= '0;
				end
			end else begin
				acc_q    <= acc_next;
				remain_q <= remain_q - 6'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		code.done |-> !code.malformed)
		else $error("decoder done and malformed together");
	assert property (@(posedge clk) disable iff (!arst_n)
		(bit_valid && fixed_width != 4'd0) |-> zeros_q == 6'd0)
		else $error("prefix count in fixed field");
	assert property (@(posedge clk) disable iff (!arst_n)
		!bit_valid |-> !code.done && !code.malformed)
		else $error("decoder result without a bit");
endmodule
`default_nettype wire
